// ===== rtl/dqd_pkg.sv =====
`timescale 1ns / 1ps
// dqd_pkg: shared sizes, opcode and status codes, and transaction types
// for the double-ended queue with delete. No dependencies.
package dqd_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int VALUE_W    = 32;
  localparam int OPCODE_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int ENTRY_CNT_W = 5;

  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DELETE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  data_value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]     read_value;
    logic [STATUS_W-1:0]    status;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } rsp_t;

  // command broadcast to every cell in the row
  typedef struct packed {
    logic                  push_back;
    logic                  push_front;
    logic                  pop_back;
    logic                  pop_front;
    logic                  del;
    logic [DATA_WIDTH-1:0] word;
  } cmd_t;

endpackage

// ===== rtl/dqd_cell.sv =====
`timescale 1ns / 1ps
// dqd_cell: one storage position of the queue row; holds a word and an
// occupancy bit and trades data with both neighbors. Depends on dqd_pkg.
module dqd_cell
  import dqd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  input  logic                  hit_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic                  hit_out,
  output logic                  tail
);

  logic match;
  logic remove;

  assign match   = valid && (data == cmd.word);
  assign hit_out = hit_in || match;
  assign tail    = valid && !right_valid;
  // pop front moves everything forward; delete moves the match and all behind it
  assign remove  = cmd.pop_front || (cmd.del && hit_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.push_front) begin
      valid <= left_valid;
    end else if (remove) begin
      valid <= right_valid;
    end else if (cmd.push_back && !valid && left_valid) begin
      valid <= 1'b1;
    end else if (cmd.pop_back && tail) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_front) begin
      data <= left_data;
    end else if (remove) begin
      data <= right_data;
    end else if (cmd.push_back && !valid && left_valid) begin
      data <= cmd.word;
    end
  end

endmodule

// ===== rtl/double_ended_queue_with_delete_core.sv =====
`timescale 1ns / 1ps
// double_ended_queue_with_delete_core: top level of the bounded deque with
// delete-by-value. Depends on dqd_pkg and dqd_cell.

// Bounded double-ended queue of DEPTH words held in a row of cells, cell 0
// being the front. Each request transaction carries an opcode (push back,
// pop back, push front, pop front, delete first match from the front) and a
// word; each one yields exactly one response transaction with the popped
// word, a status (ok, empty, full push dropped, no match) and the entry
// count after the operation. All cells compare and shift in parallel, so
// one request is taken per cycle while the request side is not stalled,
// and its response shows up in the output register on the next cycle.
// The longest path is the match chain running through the cells for
// delete. The request side stalls only while a response waits in the output
// register and the response side is stalled. No clearing pass is needed
// after reset: occupancy bits reset at once.
module double_ended_queue_with_delete_core
  import dqd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t                  cmd;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  full;
  logic                  empty;
  logic                  accept;
  logic                  found;
  logic [DATA_WIDTH-1:0] back_word;
  logic [DATA_WIDTH-1:0] read_next;
  logic [STATUS_W-1:0]   status_next;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      valid_vec;
  logic [DEPTH-1:0]      hit_vec;
  logic [DEPTH-1:0]      tail_vec;

  // one response slot; a new request goes in whenever that slot drains
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign found = hit_vec[DEPTH-1];

  // row of cells; the front cell sees the pushed word as its left neighbor,
  // the back cell sees an empty right neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] l_data;
    logic                  l_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_valid;
    logic                  h_in;

    if (i == 0) begin : g_front
      assign l_data  = cmd.word;
      assign l_valid = 1'b1;
      assign h_in    = 1'b0;
    end else begin : g_mid_l
      assign l_data  = cell_data[i-1];
      assign l_valid = valid_vec[i-1];
      assign h_in    = hit_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_data  = cell_data[i+1];
      assign r_valid = valid_vec[i+1];
    end

    dqd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .hit_in      (h_in),
      .data        (cell_data[i]),
      .valid       (valid_vec[i]),
      .hit_out     (hit_vec[i]),
      .tail        (tail_vec[i])
    );
  end

  // word in the last occupied cell, selected by the one-hot tail flags
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tail_vec[i]) begin
        back_word = back_word | cell_data[i];
      end
    end
  end

  // decode the request into a cell command and the response fields
  always_comb begin
    cmd         = '0;
    cmd.word    = req.data_value[DATA_WIDTH-1:0];
    status_next = ST_OK;
    read_next   = '0;
    count_next  = count;
    if (accept) begin
      unique case (req.opcode) inside
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            cmd.push_back  = (req.opcode == OP_PUSH_BACK);
            cmd.push_front = (req.opcode == OP_PUSH_FRONT);
            count_next     = count + 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            cmd.pop_back = 1'b1;
            read_next    = back_word;
            count_next   = count - 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            cmd.pop_front = 1'b1;
            read_next     = cell_data[0];
            count_next    = count - 1'b1;
          end
        end
        OP_DELETE: begin
          // cells only move when some occupied cell matched
          cmd.del = 1'b1;
          if (empty) begin
            status_next = ST_EMPTY;
          end else if (found) begin
            count_next = count - 1'b1;
          end else begin
            status_next = ST_NOMATCH;
          end
        end
        default: begin
          // unused opcodes leave the queue alone
        end
      endcase
    end
  end

  // fill count and response slot valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value  <= VALUE_W'(read_next);
      rsp.status      <= status_next;
      rsp.entry_count <= ENTRY_CNT_W'(count_next);
    end
  end

`ifndef NO_ASSERTIONS
  // occupancy bits of the row always agree with the fill count
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("cell occupancy does not match fill count");

  // occupied cells form one run starting at the front
  a_single_tail: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tail_vec) && (empty || valid_vec[0]))
    else $error("occupied cells are not contiguous from the front");

  // a full status is reported only with a full queue
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.entry_count == ENTRY_CNT_W'(DEPTH))
    else $error("full status with a queue that is not full");

  // a successful delete shrinks the queue by exactly one
  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && (req.opcode == OP_DELETE) && !empty && found
    |=> count == $past(count) - 1'b1)
    else $error("delete did not remove exactly one entry");
`endif

endmodule
